[src/sprite_sheet_frame_sequencer_top_macros.svh]
// assertion helpers shared by the rtl
`ifndef SPRITE_SHEET_FRAME_SEQUENCER_TOP_MACROS_SVH
`define SPRITE_SHEET_FRAME_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define SSSF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sssf check failed");

// next-cycle implication
`define SSSF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sssf check failed");

`endif

[src/sssf_pkg.sv]
`timescale 1ns / 1ps
package sssf_pkg;

    localparam int TIME_W       = 32;
    localparam int FRAME_W      = 12;
    localparam int GRID_W       = 7;
    localparam int OP_W         = 3;
    localparam int MAX_FRAMES   = 4096;
    localparam int UV_FRAC_BITS = 16;
    localparam int UV_W         = UV_FRAC_BITS + 1;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    // command codes
    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_RESUME = 3'd1;
    localparam logic [OP_W-1:0] OP_PLAY   = 3'd2;
    localparam logic [OP_W-1:0] OP_PAUSE  = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_FRAME  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_FRAME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE  = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [TIME_W-1:0] elapsed;
    } sssf_in_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_index;
        logic [UV_W-1:0]    u_left;
        logic [UV_W-1:0]    u_right;
        logic [UV_W-1:0]    v_low;
        logic [UV_W-1:0]    v_high;
        logic               is_playing;
        logic               frame_changed;
    } sssf_out_t;

endpackage

[src/sssf_divider.sv]
`timescale 1ns / 1ps
module sssf_divider #(
    parameter int QUOT_W = 12,
    parameter int DIV_W  = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  rem_init,
    input  logic [QUOT_W-1:0] dividend,
    input  logic [DIV_W-1:0]  divisor,
    output logic              done,
    output logic [QUOT_W-1:0] quotient,
    output logic [DIV_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  divisor_reg, divisor_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           ge;

    // one quotient bit per cycle, dividend shifted in msb first
    assign trial = {rem_reg, quot_reg[QUOT_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign ge    = (trial >= {1'b0, divisor_reg});

    always_comb begin
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (start && !busy_reg) begin
            quot_next    = dividend;
            rem_next     = rem_init;
            divisor_next = divisor;
            cnt_next     = CNT_W'(QUOT_W);
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quot_next = {quot_reg[QUOT_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

[src/sprite_sheet_frame_sequencer_top.sv]
`timescale 1ns / 1ps
// a transaction passes sum, compare, column, row, uv and out; a new one is taken only in idle
// and out waits for a free result register. three bit-serial restoring divisions run one after another:
// frame / cols (12 steps), quotient mod rows (12 steps), four texture edge lanes (17 steps)
// plus a done step per division, the accumulate and compare steps, and a step to load the result
// reset (aresetn low, synchronous): frame 0, time sum 0, not playing, registers to defaults
module sprite_sheet_frame_sequencer_top
    import sssf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // command transactions
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sssf_in_t              s_data,
    // result transactions
    output logic                  m_valid,
    input  logic                  m_ready,
    output sssf_out_t             m_data,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "sprite_sheet_frame_sequencer_top_macros.svh"

    localparam int NUM_LANES = 4;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SUM  = 7'b0000010,
        S_CMP  = 7'b0000100,
        S_COL  = 7'b0001000,
        S_ROW  = 7'b0010000,
        S_UV   = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [GRID_W-1:0]  grid_rows_reg, grid_rows_next;
    logic [GRID_W-1:0]  grid_cols_reg, grid_cols_next;
    logic [FRAME_W-1:0] first_frame_reg, first_frame_next;
    logic [FRAME_W-1:0] last_frame_reg, last_frame_next;
    logic [TIME_W-1:0]  period_reg, period_next;
    logic               loop_reg, loop_next;

    // animation state
    logic [FRAME_W-1:0] frame_now_reg, frame_now_next;
    logic [TIME_W-1:0]  time_sum_reg, time_sum_next;
    logic               running_reg, running_next;

    // per-transaction working registers
    logic [OP_W-1:0]    op_reg, op_next;
    logic [TIME_W-1:0]  el_reg, el_next;
    logic [TIME_W-1:0]  sum_reg, sum_next;
    logic               load_reg, load_next;
    logic               changed_reg, changed_next;
    logic [GRID_W-1:0]  col_reg, col_next;

    // result register
    logic               m_valid_reg, m_valid_next;
    sssf_out_t          m_data_reg, m_data_next;

    // datapath helpers
    logic [GRID_W-1:0]   rows_eff, cols_eff;
    logic [TIME_W:0]     sum_wide;
    logic [TIME_W:0]     diff_wide;
    logic                reached;
    logic [FRAME_W:0]    frame_inc;
    logic                past_end;
    logic [FRAME_W-1:0]  load_val;
    logic                load_now;
    logic [FRAME_W-1:0]  split_src;
    logic [2*GRID_W-1:0] reduced;

    // frame split divider, shared between the column and row steps
    logic                split_start;
    logic [FRAME_W-1:0]  split_dividend;
    logic [GRID_W-1:0]   split_divisor;
    logic                split_done;
    logic [FRAME_W-1:0]  split_quot;
    logic [GRID_W-1:0]   split_rem;

    // texture edge lanes: u_left, u_right, v_low, v_high
    logic                lane_start;
    logic [GRID_W:0]     lane_x [NUM_LANES];
    logic [GRID_W-1:0]   lane_d [NUM_LANES];
    logic [UV_W-1:0]     lane_q [NUM_LANES];
    logic [NUM_LANES-1:0] lane_done;

    // a zero grid dimension counts as one
    assign rows_eff = (grid_rows_reg == '0) ? GRID_W'(1) : grid_rows_reg;
    assign cols_eff = (grid_cols_reg == '0) ? GRID_W'(1) : grid_cols_reg;

    // saturating accumulate of elapsed time
    assign sum_wide  = {1'b0, time_sum_reg} + {1'b0, el_reg};
    // borrow clear means the accumulator reached the period
    assign diff_wide = {1'b0, sum_reg} - {1'b0, period_reg};
    assign reached   = !diff_wide[TIME_W];

    assign frame_inc = {1'b0, frame_now_reg} + 1'b1;
    assign past_end  = (frame_inc > {1'b0, last_frame_reg});

    // row * cols + col is the frame reduced modulo the cell count
    assign reduced = split_rem * cols_eff + {{GRID_W{1'b0}}, col_reg};

    // column step divides the frame by cols, row step takes that quotient mod rows
    assign split_start    = (state_reg == S_CMP) || ((state_reg == S_COL) && split_done);
    assign split_dividend = (state_reg == S_CMP) ? split_src : split_quot;
    assign split_divisor  = (state_reg == S_CMP) ? cols_eff : rows_eff;

    sssf_divider #(
        .QUOT_W (FRAME_W),
        .DIV_W  (GRID_W)
    ) u_split_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (split_start),
        .rem_init  ('0),
        .dividend  (split_dividend),
        .divisor   (split_divisor),
        .done      (split_done),
        .quotient  (split_quot),
        .remainder (split_rem)
    );

    // each lane computes x * 2^frac / d with x <= d; the remainder starts
    // with x >> 1, which is always below d, and x[0] plus zeros are shifted in
    assign lane_start = (state_reg == S_ROW) && split_done;
    assign lane_x[0]  = {1'b0, col_reg};
    assign lane_x[1]  = {1'b0, col_reg} + 1'b1;
    assign lane_x[2]  = {1'b0, split_rem};
    assign lane_x[3]  = {1'b0, split_rem} + 1'b1;
    assign lane_d[0]  = cols_eff;
    assign lane_d[1]  = cols_eff;
    assign lane_d[2]  = rows_eff;
    assign lane_d[3]  = rows_eff;

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        sssf_divider #(
            .QUOT_W (UV_W),
            .DIV_W  (GRID_W)
        ) u_uv_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .start     (lane_start),
            .rem_init  (lane_x[i][GRID_W:1]),
            .dividend  ({lane_x[i][0], {UV_FRAC_BITS{1'b0}}}),
            .divisor   (lane_d[i]),
            .done      (lane_done[i]),
            .quotient  (lane_q[i]),
            .remainder ()
        );
    end

    // register writes are always taken
    assign cfg_ready = 1'b1;

    always_comb begin
        grid_rows_next   = grid_rows_reg;
        grid_cols_next   = grid_cols_reg;
        first_frame_next = first_frame_reg;
        last_frame_next  = last_frame_reg;
        period_next      = period_reg;
        loop_next        = loop_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_GRID_ROWS:    grid_rows_next   = cfg_data[GRID_W-1:0];
                REG_GRID_COLS:    grid_cols_next   = cfg_data[GRID_W-1:0];
                REG_FIRST_FRAME:  first_frame_next = cfg_data[FRAME_W-1:0];
                REG_LAST_FRAME:   last_frame_next  = cfg_data[FRAME_W-1:0];
                REG_FRAME_PERIOD: period_next      = cfg_data[TIME_W-1:0];
                REG_LOOP_ENABLE:  loop_next        = cfg_data[0];
                default: ;
            endcase
        end
    end

    // command decode, done in the compare cycle
    always_comb begin
        time_sum_next = time_sum_reg;
        running_next  = running_reg;
        load_now      = 1'b0;
        changed_next  = changed_reg;
        load_val      = first_frame_reg;
        if (state_reg == S_CMP) begin
            changed_next = 1'b0;
            case (op_reg)
                OP_TICK: begin
                    if (running_reg) begin
                        time_sum_next = reached ? diff_wide[TIME_W-1:0] : sum_reg;
                        if (reached) begin
                            load_now     = 1'b1;
                            changed_next = 1'b1;
                            if (!past_end) begin
                                load_val = frame_inc[FRAME_W-1:0];
                            end else if (loop_reg) begin
                                load_val = first_frame_reg;
                            end else begin
                                // hold on the last frame and stop
                                load_val     = last_frame_reg;
                                running_next = 1'b0;
                            end
                        end
                    end
                end
                OP_RESUME: begin
                    running_next = 1'b1;
                end
                OP_PLAY: begin
                    load_now     = 1'b1;
                    changed_next = 1'b1;
                    running_next = 1'b1;
                end
                OP_PAUSE: begin
                    running_next = 1'b0;
                end
                OP_STOP: begin
                    load_now     = 1'b1;
                    changed_next = 1'b1;
                    running_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // a loaded frame is split; otherwise the held frame is split with the current grid
    assign split_src = load_now ? load_val : frame_now_reg;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        el_next        = el_reg;
        sum_next       = sum_reg;
        load_next      = load_reg;
        col_next       = col_reg;
        frame_now_next = frame_now_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_data.opcode;
                    el_next    = s_data.elapsed;
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                sum_next   = sum_wide[TIME_W] ? {TIME_W{1'b1}} : sum_wide[TIME_W-1:0];
                state_next = S_CMP;
            end
            S_CMP: begin
                load_next  = load_now;
                state_next = S_COL;
            end
            S_COL: begin
                if (split_done) begin
                    col_next   = split_rem;
                    state_next = S_ROW;
                end
            end
            S_ROW: begin
                if (split_done) begin
                    if (load_reg) begin
                        frame_now_next = FRAME_W'(reduced % MAX_FRAMES);
                    end
                    state_next = S_UV;
                end
            end
            S_UV: begin
                if (lane_done[0]) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // wait for the result register to free up
                if (!m_valid_reg || m_ready) begin
                    m_data_next.frame_index   = frame_now_reg;
                    m_data_next.u_left        = lane_q[0];
                    m_data_next.u_right       = lane_q[1];
                    m_data_next.v_low         = lane_q[2];
                    m_data_next.v_high        = lane_q[3];
                    m_data_next.is_playing    = running_reg;
                    m_data_next.frame_changed = changed_reg;
                    m_valid_next              = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            grid_rows_reg   <= GRID_W'(1);
            grid_cols_reg   <= GRID_W'(1);
            first_frame_reg <= '0;
            last_frame_reg  <= '0;
            period_reg      <= TIME_W'(65536);
            loop_reg        <= 1'b1;
            frame_now_reg   <= '0;
            time_sum_reg    <= '0;
            running_reg     <= 1'b0;
            load_reg        <= 1'b0;
            changed_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            grid_rows_reg   <= grid_rows_next;
            grid_cols_reg   <= grid_cols_next;
            first_frame_reg <= first_frame_next;
            last_frame_reg  <= last_frame_next;
            period_reg      <= period_next;
            loop_reg        <= loop_next;
            frame_now_reg   <= frame_now_next;
            time_sum_reg    <= time_sum_next;
            running_reg     <= running_next;
            load_reg        <= load_next;
            changed_reg     <= changed_next;
            m_valid_reg     <= m_valid_next;
        end
        // payload, no reset needed
        op_reg     <= op_next;
        el_reg     <= el_next;
        sum_reg    <= sum_next;
        col_reg    <= col_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // the edge lanes (u_left, u_right, v_low, v_high) start together and so must finish together
    `SSSF_ASSERT_IMP(a_lanes_in_step, aclk, aresetn, 1'b1,
        lane_done == '0 || lane_done == '1)

    // the split yields a position inside the grid
    `SSSF_ASSERT_IMP(a_cell_in_grid, aclk, aresetn, (state_reg == S_ROW) && split_done,
        split_rem < rows_eff && col_reg < cols_eff)

    // edges never pass 1.0 and the left and low edges stay below it
    `SSSF_ASSERT_IMP(a_edges_bounded, aclk, aresetn, state_reg == S_OUT,
        lane_q[0] < (UV_W'(1) << UV_FRAC_BITS) && lane_q[1] <= (UV_W'(1) << UV_FRAC_BITS)
        && lane_q[2] < (UV_W'(1) << UV_FRAC_BITS) && lane_q[3] <= (UV_W'(1) << UV_FRAC_BITS))

    // a finished transaction always returns to idle once its result is loaded
    `SSSF_ASSERT_NXT(a_out_to_idle, aclk, aresetn,
        (state_reg == S_OUT) && (!m_valid_reg || m_ready), m_valid && s_ready)

endmodule
